>>> sv/pow_pkg.sv
`timescale 1ns / 1ps
package pow_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CONV,
        ST_HASH,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_prev;
        logic start_cand;
        logic conv_step;
        logic hash_start;
        logic hash_step;
        logic next_cand;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic hash_done;
        logic hit;
        logic last;
        logic limit_zero;
    } stat_t;

    localparam logic [4:0] ZDC_RESET = 5'd4;
    localparam logic [63:0] LIMIT_RESET = 64'h0000_0000_FFFF_FFFF;
    localparam logic [0:0] ADDR_ZDC = 1'b0;
    localparam logic [0:0] ADDR_LIMIT = 1'b1;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> sv/pow_if.sv
`timescale 1ns / 1ps
interface pow_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] previous_proof;
    modport source (output valid, output previous_proof, input ready);
    modport sink (input valid, input previous_proof, output ready);
endinterface

interface pow_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] new_proof;
    logic        found;
    modport source (output valid, output new_proof, output found, input ready);
    modport sink (input valid, input new_proof, input found, output ready);
endinterface

>>> sv/sha256_proof_of_work_search_unit.sv
`timescale 1ns / 1ps
// Hashcash-style SHA-256 proof-of-work search. A request carries a previous
// proof; the unit hashes the decimal text of previous proof followed by the
// decimal text of candidates 0, 1, 2, ... and returns the first candidate whose
// digest starts with zero_digit_count zero hex digits (found = 1), or the last
// candidate tried, search_limit - 1, with found = 0 (0 when the limit is 0).
// One request is in flight at a time. Each candidate takes one setup step,
// 64 double-dabble steps that convert both numbers at once, 40 steps that
// write the digits into the message, one step to load the hash, 64 SHA-256
// rounds and one check. A request is accepted before the first candidate,
// and the result is held after the last until it is taken; with a zero limit
// no candidate is tried. Registers: 0x0 zero_digit_count
// (reset 4), 0x8 search_limit (64 bits, reset 0xFFFFFFFF); write only while idle.
module sha256_proof_of_work_search_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    pow_in_if.sink      in_ch,
    pow_out_if.source   out_ch
);
    logic [4:0]  zdc_reg;
    logic [63:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zdc_reg   <= pow_pkg::ZDC_RESET;
            limit_reg <= pow_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && paddr[2:0] == 3'd0 && paddr[3:3] == pow_pkg::ADDR_ZDC)
            zdc_reg <= pwdata[4:0];
        else if (psel && penable && pwrite && paddr[2:0] == 3'd0 && paddr[3:3] == pow_pkg::ADDR_LIMIT)
            limit_reg <= pwdata;
    end

    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr[2:0] == 3'd0 && paddr[3:3] == pow_pkg::ADDR_ZDC)
            prdata = {59'd0, zdc_reg};
        else if (paddr[2:0] == 3'd0)
            prdata = limit_reg;
    end

    pow_pkg::cmd_t  cmd;
    pow_pkg::stat_t stat;
    logic [63:0]    cand;
    logic           found_val, zero_res;

    pow_datapath u_dp (
        .clk              (clk),
        .previous_proof   (in_ch.previous_proof),
        .zero_digit_count (zdc_reg),
        .search_limit     (limit_reg),
        .cmd              (cmd),
        .stat             (stat),
        .cand             (cand)
    );

    pow_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .found_val (found_val),
        .zero_res  (zero_res),
        .stat      (stat),
        .cmd       (cmd)
    );

    assign out_ch.new_proof = zero_res ? 64'd0 : cand;
    assign out_ch.found     = found_val;
endmodule

>>> sv/pow_datapath.sv
`timescale 1ns / 1ps
module pow_datapath (
    input  logic             clk,
    input  logic [63:0]      previous_proof,
    input  logic [4:0]       zero_digit_count,
    input  logic [63:0]      search_limit,
    input  pow_pkg::cmd_t    cmd,
    output pow_pkg::stat_t   stat,
    output logic [63:0]      cand
);
    // Decimal conversion: both numbers run through double dabble side by side
    // (64 shift steps), then their BCD digits are written into the message one
    // byte per cycle, leading zeros skipped, previous proof first.
    localparam logic [6:0] CNT_EMIT      = 7'd64;   // first digit-emit step
    localparam logic [6:0] CNT_PREV_LAST = 7'd83;   // last digit of previous proof
    localparam logic [6:0] CNT_CAND      = 7'd84;   // first candidate digit step
    localparam logic [6:0] CNT_CAND_LAST = 7'd103;  // last digit of candidate
    localparam logic [6:0] CNT_DONE      = 7'd104;  // message complete

    logic [63:0]  prev_reg, cand_reg, cand_next;
    logic [63:0]  bin_p_reg, bin_c_reg;
    logic [79:0]  bcd_p_reg, bcd_c_reg;
    logic [79:0]  adj_p, adj_c;
    logic [6:0]   cnt_reg;
    logic         lead_reg;           // a digit of the current number was written
    logic [511:0] msg_reg;            // message bytes, byte 0 at top
    logic [5:0]   len_reg;
    logic [3:0]   top_nib;
    logic         last_dig;
    logic         emit;

    always_comb
    begin
        for (int i = 0; i < 20; i++)
        begin
            adj_p[4 * i +: 4] = (bcd_p_reg[4 * i +: 4] >= 4'd5) ?
                                bcd_p_reg[4 * i +: 4] + 4'd3 : bcd_p_reg[4 * i +: 4];
            adj_c[4 * i +: 4] = (bcd_c_reg[4 * i +: 4] >= 4'd5) ?
                                bcd_c_reg[4 * i +: 4] + 4'd3 : bcd_c_reg[4 * i +: 4];
        end
        top_nib  = (cnt_reg < CNT_CAND) ? bcd_p_reg[79:76] : bcd_c_reg[79:76];
        last_dig = (cnt_reg == CNT_PREV_LAST) || (cnt_reg == CNT_CAND_LAST);
        // the units digit is always written so zero prints as "0"
        emit     = lead_reg || (top_nib != 4'h0) || last_dig;
    end

    always_comb cand_next = cand_reg + 64'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.load_prev)
        begin
            prev_reg <= previous_proof;
            cand_reg <= '0;
        end
        if (cmd.next_cand)
            cand_reg <= cand_next;
        if (cmd.start_cand)
        begin
            bin_p_reg <= prev_reg;
            bin_c_reg <= cand_reg;
            bcd_p_reg <= '0;
            bcd_c_reg <= '0;
            cnt_reg   <= '0;
            lead_reg  <= 1'b0;
            msg_reg   <= '0;
            len_reg   <= '0;
        end
        else if (cmd.conv_step && cnt_reg != CNT_DONE)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg < CNT_EMIT)
            begin
                bcd_p_reg <= {adj_p[78:0], bin_p_reg[63]};
                bin_p_reg <= {bin_p_reg[62:0], 1'b0};
                bcd_c_reg <= {adj_c[78:0], bin_c_reg[63]};
                bin_c_reg <= {bin_c_reg[62:0], 1'b0};
            end
            else
            begin
                if (cnt_reg < CNT_CAND)
                    bcd_p_reg <= {bcd_p_reg[75:0], 4'h0};
                else
                    bcd_c_reg <= {bcd_c_reg[75:0], 4'h0};
                if (emit)
                begin
                    msg_reg[511 - 8 * int'(len_reg) -: 8] <= {4'h3, top_nib};
                    len_reg <= len_reg + 6'd1;
                end
                lead_reg <= emit && !last_dig;
            end
        end
    end

    // SHA-256 single block, one round per cycle
    logic [511:0] w_reg;
    logic [255:0] st_reg;
    logic [6:0]   rnd_reg;
    logic [255:0] dig;
    logic [511:0] blk;
    logic [31:0]  a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn;

    always_comb
    begin
        blk = msg_reg;
        blk[511 - 8 * int'(len_reg) -: 8] = 8'h80;
        blk[63:0] = {55'd0, len_reg, 3'd0};
    end

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = st_reg;
        t1 = h + (pow_pkg::ror(e, 6) ^ pow_pkg::ror(e, 11) ^ pow_pkg::ror(e, 25))
             + ((e & f) ^ (~e & g)) + pow_pkg::ROUND_K[rnd_reg[5:0]] + w_reg[511:480];
        t2 = (pow_pkg::ror(a, 2) ^ pow_pkg::ror(a, 13) ^ pow_pkg::ror(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));
        s0 = pow_pkg::ror(w_reg[479:448], 7) ^ pow_pkg::ror(w_reg[479:448], 18)
             ^ (w_reg[479:448] >> 3);
        s1 = pow_pkg::ror(w_reg[63:32], 17) ^ pow_pkg::ror(w_reg[63:32], 19)
             ^ (w_reg[63:32] >> 10);
        wn = w_reg[511:480] + s0 + w_reg[223:192] + s1;
        for (int i = 0; i < 8; i++)
            dig[32 * i +: 32] = st_reg[32 * i +: 32] + pow_pkg::INIT_H[32 * i +: 32];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hash_start)
        begin
            w_reg   <= blk;
            st_reg  <= pow_pkg::INIT_H;
            rnd_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            w_reg   <= {w_reg[479:0], wn};
            st_reg  <= {t1 + t2, a, b, c, d + t1, e, f, g};
            rnd_reg <= rnd_reg + 7'd1;
        end
    end

    logic hit;
    always_comb
    begin
        hit = 1'b1;
        for (int k = 0; k < 32; k++)
            if (5'(k) < zero_digit_count && dig[255 - 4 * k -: 4] != 4'h0)
                hit = 1'b0;
    end

    // both done flags are high during the final step of their phase
    assign stat.conv_done  = (cnt_reg == CNT_DONE);
    assign stat.hash_done  = (rnd_reg == 7'd63);
    assign stat.hit        = hit;
    assign stat.last       = (cand_next == search_limit);
    assign stat.limit_zero = (search_limit == 64'd0);
    assign cand            = cand_reg;
endmodule

>>> sv/pow_ctrl.sv
`timescale 1ns / 1ps
module pow_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            found_val,
    output logic            zero_res,
    input  pow_pkg::stat_t  stat,
    output pow_pkg::cmd_t   cmd
);
    pow_pkg::state_t state_reg, state_next;
    logic found_reg, found_next, zero_reg, zero_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pow_pkg::ST_IDLE;
            found_reg <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            zero_reg  <= zero_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        found_next = found_reg;
        zero_next  = zero_reg;
        case (state_reg)
            pow_pkg::ST_IDLE:
                if (in_valid)
                    state_next = pow_pkg::ST_PREP;
            pow_pkg::ST_PREP:
            begin
                zero_next  = stat.limit_zero;
                found_next = 1'b0;
                state_next = stat.limit_zero ? pow_pkg::ST_DONE : pow_pkg::ST_CONV;
            end
            pow_pkg::ST_CONV:
                if (stat.conv_done)
                    state_next = pow_pkg::ST_HASH;
            pow_pkg::ST_HASH:
                if (stat.hash_done)
                    state_next = pow_pkg::ST_CHECK;
            pow_pkg::ST_CHECK:
            begin
                if (stat.hit)
                begin
                    found_next = 1'b1;
                    state_next = pow_pkg::ST_DONE;
                end
                else if (stat.last)
                    state_next = pow_pkg::ST_DONE;
                else
                    state_next = pow_pkg::ST_PREP;
            end
            pow_pkg::ST_DONE:
                if (out_ready)
                    state_next = pow_pkg::ST_IDLE;
            default:
                state_next = pow_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            pow_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_prev = in_valid;
            end
            pow_pkg::ST_PREP:
                cmd.start_cand = 1'b1;
            pow_pkg::ST_CONV:
            begin
                cmd.conv_step  = 1'b1;
                cmd.hash_start = stat.conv_done;
            end
            pow_pkg::ST_HASH:
                cmd.hash_step = 1'b1;
            pow_pkg::ST_CHECK:
                cmd.next_cand = !stat.hit && !stat.last;
            pow_pkg::ST_DONE:
                out_valid = 1'b1;
            default:
                cmd = '0;
        endcase
    end

    assign found_val = found_reg;
    assign zero_res  = zero_reg;
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int CYCLE_LIMIT = 30_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [3:0] REG_ZDC = 4'h0;
    localparam logic [3:0] REG_LIMIT = 4'h8;

    typedef struct {
        logic [63:0] new_proof;
        logic        found;
    } proof_t;

    // Proof predictor plus queue of pending proofs. It keeps its own copy of
    // the two registers; the driver updates them when it programs the unit.
    class proof_scoreboard;
        logic [4:0]  zdc;
        logic [63:0] limit;
        proof_t      pending[$];
        int          errors;
        int          checked;
        int          hits;

        function new();
            zdc = pow_pkg::ZDC_RESET;
            limit = pow_pkg::LIMIT_RESET;
            errors = 0;
            checked = 0;
            hits = 0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // decimal text of v, most significant digit first, "0" for zero
        function int append_dec(ref logic [7:0] m[64], input int pos, input logic [63:0] v);
            logic [7:0] tmp[20];
            int n;
            n = 0;
            do begin
                tmp[n] = 8'd48 + 8'(v % 10);
                v = v / 10;
                n++;
            end while (v != 0);
            while (n > 0) begin
                n--;
                m[pos] = tmp[n];
                pos++;
            end
            return pos;
        endfunction

        function logic [255:0] sha_digest(logic [63:0] prev, logic [63:0] cand);
            logic [7:0]  m[64];
            logic [31:0] w[64];
            logic [31:0] hv[8];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
            logic [15:0] nbits;
            int len;
            foreach (m[i]) m[i] = 8'h00;
            len = append_dec(m, 0, prev);
            len = append_dec(m, len, cand);
            m[len] = 8'h80;
            nbits = 16'(len * 8);
            m[63] = nbits[7:0];
            m[62] = nbits[15:8];
            for (int i = 0; i < 16; i++)
                w[i] = {m[4*i], m[4*i+1], m[4*i+2], m[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            for (int i = 0; i < 8; i++)
                hv[i] = pow_pkg::INIT_H[255 - 32*i -: 32];
            {a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
            for (int i = 0; i < 64; i++)
            begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                     + pow_pkg::ROUND_K[i] + w[i];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            return {hv[0] + a, hv[1] + b, hv[2] + c, hv[3] + d,
                    hv[4] + e, hv[5] + f, hv[6] + g, hv[7] + h};
        endfunction

        function bit meets_zeros(logic [255:0] dg);
            for (int k = 0; k < int'(zdc) && k < 64; k++)
                if (dg[255 - 4*k -: 4] != 4'h0)
                    return 0;
            return 1;
        endfunction

        function void note_request(logic [63:0] prev);
            proof_t p;
            p.found = 0;
            p.new_proof = (limit == 0) ? 64'd0 : limit - 1;
            for (logic [63:0] c = 0; c < limit; c++)
                if (meets_zeros(sha_digest(prev, c)))
                begin
                    p.new_proof = c;
                    p.found = 1;
                    break;
                end
            pending = {pending, p};
        endfunction

        function void check_result(logic [63:0] np, logic fnd);
            proof_t p;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result new_proof=%0d found=%0b", np, fnd);
                errors++;
                return;
            end
            p = pending.pop_front();
            if (fnd) hits++;
            if (np !== p.new_proof)
            begin
                $error("new_proof: expected %0d, got %0d", p.new_proof, np);
                errors++;
            end
            if (fnd !== p.found)
            begin
                $error("found: expected %0b, got %0b", p.found, fnd);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          cycles = 0;
    int          sent = 0;
    int          stall_mode = 0;

    pow_in_if  in_ch ();
    pow_out_if out_ch ();

    proof_scoreboard sb = new();

    sha256_proof_of_work_search_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    initial
    begin
        in_ch.valid = 0;
        in_ch.previous_proof = '0;
        out_ch.ready = 0;
    end

    always #1 clk = ~clk;

    // watchdog: a hung search never reaches the end of the stimulus
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sha256_proof_of_work_search_unit test failed");
            $finish;
        end
    end

    // Result side: check accepted proofs, then pick the next ready value.
    // stall_mode 0 keeps ready high; otherwise stalls are random, mostly short.
    int ready_hold = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.new_proof, out_ch.found);
            if (ready_hold > 0)
                ready_hold <= ready_hold - 1;
            else if (stall_mode == 0)
                out_ch.ready <= 1;
            else if ($urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 0;
                ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 3);
            end
            else
                out_ch.ready <= 1;
        end
    end

    // APB write: setup cycle, then access cycle; the register takes the data
    // at the edge that ends the access cycle.
    task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == REG_ZDC) sb.zdc = data[4:0];
        else sb.limit = data;
    endtask

    task automatic set_search(input logic [4:0] zeros, input logic [63:0] lim);
        reg_write(REG_ZDC, {59'd0, zeros});
        reg_write(REG_LIMIT, lim);
    endtask

    // Send one request; valid stays high across back-to-back requests.
    task automatic send_request(input logic [63:0] prev, input bit idle);
        int gap;
        gap = 0;
        if (idle)
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.previous_proof <= prev;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_request(prev);
        sent++;
    endtask

    // Drop valid, wait for every outstanding proof, then let the unit settle
    // before the registers are touched again.
    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random previous proof: mostly short decimal text to keep searches cheap,
    // some full-width values so every input bit toggles.
    function automatic logic [63:0] rand_prev();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 64'($urandom_range(0, 9999));
        if (pick < 8) return 64'($urandom);
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // zero difficulty: candidate 0 always wins, widest search limit
        stall_mode = 0;
        set_search(5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(64'd0, 0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_request(64'd9, 0);
        send_request(64'd10, 0);
        send_request(64'h5555_5555_5555_5555, 1);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 1);
        send_request(64'd9999999999999999999, 1);
        drain();

        // one zero digit, moderate limit
        stall_mode = 1;
        set_search(5'd1, 64'd64);
        send_request(64'd0, 1);
        send_request(64'd1, 1);
        send_request(64'd12345, 1);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 1);
        drain();

        // two digits with a short limit: mix of hits and give-ups
        set_search(5'd2, 64'd20);
        for (int i = 0; i < 10; i++) send_request(64'($urandom_range(0, 999)), 1);
        drain();

        // difficulty far above reach: never found, last candidate reported
        set_search(5'd31, 64'd3);
        send_request(64'd7, 1);
        send_request(64'd123456789, 1);
        drain();

        set_search(5'd16, 64'd1);
        send_request(64'd42, 0);
        send_request(64'd0, 1);
        drain();

        // zero limit: nothing tried at all
        set_search(5'd4, 64'd0);
        send_request(64'd5, 1);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 1);
        drain();

        // main random run at one zero digit, unlimited search
        set_search(5'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 73; i++)
        begin
            if (i % 20 == 0) stall_mode = (i / 20) % 2;
            send_request(rand_prev(), (i % 20) >= 5);
        end
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d proof searches, checked %0d results (%0d found) over %0d cycles.",
                 sent, sb.checked, sb.hits, cycles);
        $display("Difficulties 0, 1, 2, 4, 16 and 31, limits 0 to 2^64-1, random stalls.");
        if (sb.errors == 0)
            $display("sha256_proof_of_work_search_unit test passed");
        else
            $display("sha256_proof_of_work_search_unit test failed");
        $finish;
    end
endmodule
